/* hw/rtl/sstf_pkg.sv */
// Shared constants, word types and chain types for the SSTF disk scheduler.
package sstf_pkg;

   // Sizing
   localparam int MAX_REQUESTS = 32;
   localparam int CYL_BITS     = 16;
   localparam int IDX_BITS     = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_BITS     = $clog2(MAX_REQUESTS + 1);
   localparam int SUM_BITS     = 22;

   // Input word kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_GO   = 1'b1;

   // Request word
   typedef struct packed {
      logic        kind;
      logic [15:0] cylinder;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [15:0]         served_cylinder;
      logic [15:0]         seek_distance;
      logic [SUM_BITS-1:0] total_seek;
      logic [6:0]          request_count;
      logic                last;
   } rsp_word_type;

   // Best candidate so far, handed down the chain
   typedef struct packed {
      logic                found;
      logic [CYL_BITS-1:0] gap;
      logic [CYL_BITS-1:0] cyl;
      logic [IDX_BITS-1:0] idx;
   } cand_type;

   // Broadcast control from the sequencer to every cell
   typedef struct packed {
      logic                load_en;
      logic [IDX_BITS-1:0] load_idx;
      logic [CYL_BITS-1:0] load_cyl;
      logic                pick_en;
      logic [IDX_BITS-1:0] pick_idx;
      logic [CYL_BITS-1:0] head;
   } cell_ctrl_type;

endpackage

/* hw/rtl/sstf_cell.sv */
// One cell of the request chain: holds a request and compares it with the incoming best.
module sstf_cell
   import sstf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_BITS-1:0] cell_idx,
   input  cell_ctrl_type       ctrl,
   input  cand_type            cand_prev,
   output cand_type            cand_next
);

   logic [CYL_BITS-1:0] cyl_ff, cyl_in;
   logic                pending_ff, pending_in;
   cand_type            cand_ff, cand_in;
   logic [CYL_BITS-1:0] gap;
   logic                take;

   // distance from the head, and strict compare so earlier cells win ties
   always_comb begin
      gap  = (cyl_ff >= ctrl.head) ? (cyl_ff - ctrl.head) : (ctrl.head - cyl_ff);
      take = pending_ff && (!cand_prev.found || (gap < cand_prev.gap));
      if (take) begin
         cand_in.found = 1'b1;
         cand_in.gap   = gap;
         cand_in.cyl   = cyl_ff;
         cand_in.idx   = cell_idx;
      end else begin
         cand_in = cand_prev;
      end
   end

   // request storage and unserved flag
   always_comb begin
      cyl_in     = cyl_ff;
      pending_in = pending_ff;
      if (ctrl.load_en && (ctrl.load_idx == cell_idx)) begin
         cyl_in     = ctrl.load_cyl;
         pending_in = 1'b1;
      end else if (ctrl.pick_en && (ctrl.pick_idx == cell_idx)) begin
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cyl_ff <= cyl_in;
      if (reset) begin
         pending_ff <= 1'b0;
         cand_ff    <= '0;
      end else begin
         pending_ff <= pending_in;
         cand_ff    <= cand_in;
      end
   end

   assign cand_next = cand_ff;

endmodule

/* hw/rtl/sstf_disk_scheduler.sv */
// Top level of the SSTF disk scheduler: sequencer plus a chain of request cells.
//
//  channel   ports                             direction  handshake
//  request   start, busy, req_word             in         taken when start && !busy
//  result    rsp_strobe, rsp_word              out        one-cycle strobe, no back-pressure
//
// A go word sweeps the chain once per pick: a candidate ripples one cell a cycle down
// the chain, and the sequencer issues a pick when the winner reaches the end of it. An
// empty go gives its single result the cycle after it is taken. busy is high from a
// non-empty go until the last result is issued. Reset clears the sequencer state, the
// request count and all unserved flags.
module sstf_disk_scheduler
   import sstf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] timer_ff, timer_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] done_ff, done_in;
   logic [CYL_BITS-1:0] head_ff, head_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;

   cell_ctrl_type       ctrl;
   cand_type            cand_link [0:MAX_REQUESTS];
   cand_type            pick;
   logic                accept;
   logic [CYL_BITS-1:0] in_cyl;

   assign accept    = start && (state_ff == ST_IDLE);
   assign in_cyl    = req_word.cylinder[CYL_BITS-1:0];
   assign pick      = cand_link[MAX_REQUESTS];
   assign cand_link[0] = '0;

   // chain of cells
   for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
      sstf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_BITS'(i)),
         .ctrl      (ctrl),
         .cand_prev (cand_link[i]),
         .cand_next (cand_link[i+1])
      );
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      timer_in      = timer_ff;
      count_in      = count_ff;
      done_in       = done_ff;
      head_in       = head_ff;
      sum_in        = sum_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      ctrl.load_en  = 1'b0;
      ctrl.load_idx = count_ff[IDX_BITS-1:0];
      ctrl.load_cyl = in_cyl;
      ctrl.pick_en  = 1'b0;
      ctrl.pick_idx = pick.idx;
      ctrl.head     = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_word.kind == KIND_LOAD)) begin
               // ignore loads once the store is full
               if (count_ff < CNT_BITS'(MAX_REQUESTS)) begin
                  ctrl.load_en = 1'b1;
                  count_in     = count_ff + 1'b1;
               end
            end else if (accept && (req_word.kind == KIND_GO)) begin
               head_in = in_cyl;
               sum_in  = '0;
               if (count_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_word_in   = '0;
                  rsp_word_in.last = 1'b1;
               end else begin
                  timer_in = '0;
                  done_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (timer_ff == CNT_BITS'(MAX_REQUESTS)) begin
               // winner has reached the end of the chain
               ctrl.pick_en  = 1'b1;
               head_in       = pick.cyl;
               sum_in        = sum_ff + SUM_BITS'(pick.gap);
               done_in       = done_ff + 1'b1;
               timer_in      = '0;
               rsp_strobe_in = 1'b1;
               rsp_word_in.served_cylinder = 16'(pick.cyl);
               rsp_word_in.seek_distance   = 16'(pick.gap);
               rsp_word_in.total_seek      = sum_in;
               rsp_word_in.request_count   = 7'(count_ff);
               rsp_word_in.last            = (done_in == count_ff);
               if (done_in == count_ff) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end
            end else begin
               timer_in = timer_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      timer_ff    <= timer_in;
      done_ff     <= done_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         head_ff       <= '0;
         sum_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         head_ff       <= head_in;
         sum_ff        <= sum_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

/* verif/tb_sstf_disk_scheduler.sv */
// Self-checking testbench for the SSTF disk scheduler: queued stimulus, predictor, monitor.
`timescale 1ns / 100ps

module tb_sstf_disk_scheduler
   import sstf_pkg::*;
();

   localparam logic [15:0] CYL_MASK    = 16'((32'd1 << CYL_BITS) - 1);
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          DRAIN_WAIT  = 2 * (MAX_REQUESTS + 1);
   localparam int          RANDOM_WORDS = 450;

   typedef struct {
      req_word_type word;
      bit           hold_for_drain;
   } pending_type;

   logic         clock;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_word_type req_word = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   pending_type  pending_words[$];
   rsp_word_type expected_picks[$];

   // Predictor state: the loaded cylinders of the current batch
   logic [15:0]  queued_cyl[MAX_REQUESTS];
   int           queued_count = 0;

   int           words_taken    = 0;
   int           picks_seen     = 0;
   int           mismatch_count = 0;
   int           cycle_count    = 0;

   sstf_disk_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // Load stores a cylinder; go serves the batch nearest-first and queues every pick
   function automatic void apply_request(input req_word_type w);
      logic [15:0]             cyl;
      logic [15:0]             head;
      logic [15:0]             gap;
      logic [16:0]             best;
      logic [SUM_BITS-1:0]     sum;
      logic [MAX_REQUESTS-1:0] served;
      rsp_word_type            pick_word;
      int                      pick;
      cyl = w.cylinder & CYL_MASK;
      if (w.kind == KIND_LOAD) begin
         if (queued_count < MAX_REQUESTS) begin
            queued_cyl[queued_count] = cyl;
            queued_count++;
         end
      end else if (queued_count == 0) begin
         pick_word      = '0;
         pick_word.last = 1'b1;
         expected_picks.push_back(pick_word);
      end else begin
         head   = cyl;
         sum    = '0;
         served = '0;
         for (int step = 0; step < queued_count; step++) begin
            best = 17'h1FFFF;
            pick = 0;
            // strict compare keeps the earliest entry on equal distances
            for (int k = 0; k < queued_count; k++) begin
               if (!served[k]) begin
                  gap = (head > queued_cyl[k]) ? head - queued_cyl[k] : queued_cyl[k] - head;
                  if ({1'b0, gap} < best) begin
                     best = {1'b0, gap};
                     pick = k;
                  end
               end
            end
            served[pick]              = 1'b1;
            sum                       = sum + SUM_BITS'(best);
            head                      = queued_cyl[pick];
            pick_word.served_cylinder = head;
            pick_word.seek_distance   = best[15:0];
            pick_word.total_seek      = sum;
            pick_word.request_count   = 7'(queued_count);
            pick_word.last            = (step + 1 == queued_count);
            expected_picks.push_back(pick_word);
         end
         queued_count = 0;
      end
   endfunction

   // Request driver: holds start until the word is taken, idles at random between words
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_request(req_word);
            void'(pending_words.pop_front());
            words_taken++;
         end
         if (!start || !busy) begin
            if (pending_words.size() != 0 &&
                (!pending_words[0].hold_for_drain || expected_picks.size() == 0) &&
                ((words_taken >= 200 && words_taken < 320) || $urandom_range(99) >= 34)) begin
               start    <= 1'b1;
               req_word <= pending_words[0].word;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor: every strobed word is checked against the oldest pick
   always @(posedge clock) begin : result_monitor
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (expected_picks.size() == 0) begin
            log_mismatch($sformatf("unexpected result word %h", rsp_word));
         end else begin
            want = expected_picks.pop_front();
            if (rsp_word.served_cylinder !== want.served_cylinder)
               log_mismatch($sformatf("word %0d served_cylinder %h, want %h", picks_seen,
                                      rsp_word.served_cylinder, want.served_cylinder));
            if (rsp_word.seek_distance !== want.seek_distance)
               log_mismatch($sformatf("word %0d seek_distance %h, want %h", picks_seen,
                                      rsp_word.seek_distance, want.seek_distance));
            if (rsp_word.total_seek !== want.total_seek)
               log_mismatch($sformatf("word %0d total_seek %h, want %h", picks_seen,
                                      rsp_word.total_seek, want.total_seek));
            if (rsp_word.request_count !== want.request_count)
               log_mismatch($sformatf("word %0d request_count %0d, want %0d", picks_seen,
                                      rsp_word.request_count, want.request_count));
            if (rsp_word.last !== want.last)
               log_mismatch($sformatf("word %0d last %b, want %b", picks_seen,
                                      rsp_word.last, want.last));
         end
         picks_seen++;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic queue_word(input logic kind, input logic [15:0] cyl, input bit hold = 1'b0);
      pending_type p;
      p.word.kind     = kind;
      p.word.cylinder = cyl;
      p.hold_for_drain = hold;
      pending_words.push_back(p);
   endtask

   // Cylinder of a given flavour: anywhere, clustered near base (ties), or at the extremes
   function automatic logic [15:0] pick_cylinder(input int flavour, input logic [15:0] base);
      logic [15:0] c;
      case (flavour)
         0: begin
            c = 16'($urandom);
         end
         1: begin
            c = base + 16'($urandom_range(16)) - 16'd8;
         end
         default: begin
            case ($urandom_range(3))
               0: c = 16'h0000;
               1: c = 16'hFFFF;
               2: c = 16'h0001;
               default: c = 16'($urandom);
            endcase
         end
      endcase
      return c;
   endfunction

   // Stimulus
   initial begin
      int          random_words;
      int          batch_size;
      int          roll;
      int          flavour;
      logic [15:0] base;

      // Go on an empty store
      queue_word(KIND_GO, 16'h1234);
      // Cylinder extremes, head in the middle
      queue_word(KIND_LOAD, 16'hFFFF);
      queue_word(KIND_LOAD, 16'h0000);
      queue_word(KIND_GO, 16'h7FFF);
      // Equal distances and a duplicate cylinder
      queue_word(KIND_LOAD, 16'd100);
      queue_word(KIND_LOAD, 16'd300);
      queue_word(KIND_LOAD, 16'd300);
      queue_word(KIND_GO, 16'd200);
      // Request sitting under the head
      queue_word(KIND_LOAD, 16'h5555);
      queue_word(KIND_GO, 16'h5555);
      // Head at zero and at the top, alternating bit patterns
      queue_word(KIND_LOAD, 16'hAAAA);
      queue_word(KIND_LOAD, 16'h5555);
      queue_word(KIND_GO, 16'h0000);
      queue_word(KIND_LOAD, 16'h0001);
      queue_word(KIND_LOAD, 16'hFFFE);
      queue_word(KIND_GO, 16'hFFFF);
      // Back-to-back empty goes
      queue_word(KIND_GO, 16'hFFFF);
      queue_word(KIND_GO, 16'h0000);

      // Overfull batch after the pipeline has emptied: the extra loads are dropped
      random_words = 0;
      for (int i = 0; i < MAX_REQUESTS + 3; i++) begin
         queue_word(KIND_LOAD, 16'($urandom), i == 0);
         random_words++;
      end
      queue_word(KIND_GO, 16'($urandom));
      random_words++;

      // Random batches, mostly small
      while (random_words < RANDOM_WORDS) begin
         roll = $urandom_range(99);
         if (roll < 60)      batch_size = $urandom_range(1, 8);
         else if (roll < 82) batch_size = $urandom_range(9, MAX_REQUESTS);
         else if (roll < 90) batch_size = MAX_REQUESTS + $urandom_range(1, 5);
         else                batch_size = 0;
         flavour = $urandom_range(2);
         base    = 16'($urandom);
         for (int i = 0; i < batch_size; i++) begin
            queue_word(KIND_LOAD, pick_cylinder(flavour, base),
                       i == 0 && $urandom_range(99) < 4);
            random_words++;
         end
         queue_word(KIND_GO, pick_cylinder(flavour, base));
         random_words++;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || expected_picks.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
